[design/rth_pkg.sv]
// Package for the RGB to HSV converter.
// Holds the hue format constants and the max-channel select type; no dependencies.
`default_nettype none
package rth_pkg;

	localparam int HUE_W         = 11;
	localparam int SEXTANT_SHIFT = 8;

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} max_sel_t;

endpackage
`default_nettype wire

[design/rth_pix_if.sv]
// Input pixel channel of the RGB to HSV converter: valid, ready and the RGB payload.
// No dependencies.
`default_nettype none
interface rth_pix_if #(
	parameter int CHANNEL_BITS = 8
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

[design/rth_hsv_if.sv]
// Output channel of the RGB to HSV converter: valid, ready and the HSV payload.
// Depends on rth_pkg for the hue width.
`default_nettype none
interface rth_hsv_if
	import rth_pkg::*;
#(
	parameter int CHANNEL_BITS = 8
);
	logic                    valid;
	logic                    ready;
	logic [HUE_W-1:0]        hue;
	logic [CHANNEL_BITS-1:0] saturation;
	logic [CHANNEL_BITS-1:0] brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface
`default_nettype wire

[design/rth_front.sv]
// Front stages of the converter: max, min and delta, then the hue and saturation dividends.
// Depends on rth_pkg.
`default_nettype none
module rth_front
	import rth_pkg::*;
#(
	parameter int CHANNEL_BITS = 8,
	parameter int NSTEP        = 11
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          vld_i,
	input  wire logic [CHANNEL_BITS-1:0]       red,
	input  wire logic [CHANNEL_BITS-1:0]       green,
	input  wire logic [CHANNEL_BITS-1:0]       blue,
	output logic                               vld_o,
	output logic [CHANNEL_BITS+NSTEP-1:0]      hue_dvd,
	output logic [CHANNEL_BITS+NSTEP-1:0]      sat_dvd,
	output logic [CHANNEL_BITS-1:0]            delta,
	output logic [CHANNEL_BITS-1:0]            brightness,
	output logic                               hue_zero,
	output logic                               sat_zero
);
	localparam int CB = CHANNEL_BITS;
	localparam int TW = CB + 3;
	localparam int DW = CB + NSTEP;

	logic [CB-1:0] mx;
	logic [CB-1:0] mn;
	max_sel_t      sel;

	logic          vld_s1;
	logic [CB-1:0] r_s1;
	logic [CB-1:0] g_s1;
	logic [CB-1:0] b_s1;
	logic [CB-1:0] mx_s1;
	logic [CB-1:0] delta_s1;
	max_sel_t      sel_s1;

	logic [TW-1:0]   d_ext;
	logic [TW-1:0]   top;
	logic [2*CB-1:0] sat_prod;

	logic          vld_s2;
	logic [DW-1:0] hue_dvd_s2;
	logic [DW-1:0] sat_dvd_s2;
	logic [CB-1:0] delta_s2;
	logic [CB-1:0] mx_s2;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (red >= green && red >= blue) begin
			sel = SEL_RED;
		end else if (green >= blue) begin
			sel = SEL_GREEN;
		end else begin
			sel = SEL_BLUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1     <= red;
			g_s1     <= green;
			b_s1     <= blue;
			mx_s1    <= mx;
			delta_s1 <= mx - mn;
			sel_s1   <= sel;
		end
	end

	always_comb begin
		d_ext = TW'(delta_s1);
		case (sel_s1)
			SEL_RED: begin
				if (g_s1 >= b_s1) begin
					top = TW'(g_s1) - TW'(b_s1);
				end else begin
					top = (d_ext << 2) + (d_ext << 1) - (TW'(b_s1) - TW'(g_s1));
				end
			end
			SEL_GREEN: top = (d_ext << 1) + TW'(b_s1) - TW'(r_s1);
			SEL_BLUE:  top = (d_ext << 2) + TW'(r_s1) - TW'(g_s1);
			default:   top = '0;
		endcase
		sat_prod = {delta_s1, {CB{1'b0}}} - {{CB{1'b0}}, delta_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_dvd_s2 <= DW'({top, {SEXTANT_SHIFT{1'b0}}});
			sat_dvd_s2 <= DW'(sat_prod);
			delta_s2   <= delta_s1;
			mx_s2      <= mx_s1;
		end
	end

	assign vld_o      = vld_s2;
	assign hue_dvd    = hue_dvd_s2;
	assign sat_dvd    = sat_dvd_s2;
	assign delta      = delta_s2;
	assign brightness = mx_s2;
	assign hue_zero   = (delta_s2 == '0);
	assign sat_zero   = (mx_s2 == '0);
endmodule
`default_nettype wire

[design/rth_div.sv]
// Pipelined restoring divider, one quotient bit per register stage, with a sideband.
// The quotient must fit in Q_W bits. No dependencies.
`default_nettype none
module rth_div #(
	parameter int DVS_W  = 8,
	parameter int Q_W    = 11,
	parameter int SIDE_W = 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   vld_i,
	input  wire logic [DVS_W+Q_W-1:0]   dividend,
	input  wire logic [DVS_W-1:0]       divisor,
	input  wire logic [SIDE_W-1:0]      side_i,
	output logic                        vld_o,
	output logic [Q_W-1:0]              quotient,
	output logic [SIDE_W-1:0]           side_o
);
	logic [DVS_W-1:0]  rem_s  [0:Q_W];
	logic [Q_W-1:0]    lo_s   [0:Q_W];
	logic [Q_W-1:0]    q_s    [0:Q_W];
	logic [DVS_W-1:0]  dvs_s  [0:Q_W];
	logic [SIDE_W-1:0] side_s [0:Q_W];
	logic              vld_s  [0:Q_W];

	assign rem_s[0]  = dividend[DVS_W+Q_W-1:Q_W];
	assign lo_s[0]   = dividend[Q_W-1:0];
	assign q_s[0]    = '0;
	assign dvs_s[0]  = divisor;
	assign side_s[0] = side_i;
	assign vld_s[0]  = vld_i;

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [DVS_W:0] trial;
		logic [DVS_W:0] diff;
		logic           ge;

		always_comb begin
			trial = {rem_s[k], lo_s[k][Q_W-1]};
			diff  = trial - {1'b0, dvs_s[k]};
			ge    = (trial >= {1'b0, dvs_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
				lo_s[k+1]   <= lo_s[k] << 1;
				q_s[k+1]    <= {q_s[k][Q_W-2:0], ge};
				dvs_s[k+1]  <= dvs_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_o    = vld_s[Q_W];
	assign quotient = q_s[Q_W];
	assign side_o   = side_s[Q_W];
endmodule
`default_nettype wire

[design/rgb_to_hsv.sv]
// RGB to HSV converter, top level. Depends on rth_pkg, rth_pix_if, rth_hsv_if,
// rth_front and rth_div.
// The pipeline has two front stages, then one register stage per quotient bit in the
// two dividers, which run side by side.
// Throughput is one pixel per cycle; a stall at the output holds the whole pipeline.
// Reset clears the valid bits of every stage; the data registers are not reset.
`default_nettype none
module rgb_to_hsv
	import rth_pkg::*;
#(
	parameter int CHANNEL_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	rth_pix_if.sink  pix,
	rth_hsv_if.source hsv
);
	localparam int CB    = CHANNEL_BITS;
	localparam int NSTEP = (CB > HUE_W) ? CB : HUE_W;
	localparam int DW    = CB + NSTEP;

	logic          en;
	logic          f_vld;
	logic [DW-1:0] hue_dvd;
	logic [DW-1:0] sat_dvd;
	logic [CB-1:0] delta;
	logic [CB-1:0] mx;
	logic          hue_zero;
	logic          sat_zero;

	logic             hue_vld;
	logic [NSTEP-1:0] hue_q;
	logic             hue_zero_o;
	logic             sat_vld;
	logic [NSTEP-1:0] sat_q;
	logic [CB:0]      sat_side;

	assign en        = !hsv.valid || hsv.ready;
	assign pix.ready = en;

	rth_front #(
		.CHANNEL_BITS(CB),
		.NSTEP       (NSTEP)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_i     (pix.valid),
		.red       (pix.red),
		.green     (pix.green),
		.blue      (pix.blue),
		.vld_o     (f_vld),
		.hue_dvd   (hue_dvd),
		.sat_dvd   (sat_dvd),
		.delta     (delta),
		.brightness(mx),
		.hue_zero  (hue_zero),
		.sat_zero  (sat_zero)
	);

	rth_div #(
		.DVS_W (CB),
		.Q_W   (NSTEP),
		.SIDE_W(1)
	) u_hue_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (f_vld),
		.dividend(hue_dvd),
		.divisor (delta),
		.side_i  (hue_zero),
		.vld_o   (hue_vld),
		.quotient(hue_q),
		.side_o  (hue_zero_o)
	);

	rth_div #(
		.DVS_W (CB),
		.Q_W   (NSTEP),
		.SIDE_W(CB + 1)
	) u_sat_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (f_vld),
		.dividend(sat_dvd),
		.divisor (mx),
		.side_i  ({sat_zero, mx}),
		.vld_o   (sat_vld),
		.quotient(sat_q),
		.side_o  (sat_side)
	);

	assign hsv.valid      = hue_vld && sat_vld;
	assign hsv.hue        = hue_zero_o ? '0 : hue_q[HUE_W-1:0];
	assign hsv.saturation = sat_side[CB] ? '0 : sat_q[CB-1:0];
	assign hsv.brightness = sat_side[CB-1:0];
endmodule
`default_nettype wire

[test/tb_rgb_to_hsv.sv]
// Self-checking testbench for the rgb_to_hsv pixel converter, with random flow control.
// A local predictor computes hue, saturation and value; results are checked in order.
// Depends on rth_pkg, rth_pix_if, rth_hsv_if and the rgb_to_hsv top level.
`default_nettype none
module tb_rgb_to_hsv;
	timeunit 1ns;
	timeprecision 1ps;
	import rth_pkg::*;

	localparam int            CB        = 8;
	localparam logic [CB-1:0] FULL      = '1;
	localparam int            DRAIN_CYC = 2 + ((HUE_W > CB) ? HUE_W : CB) + 10;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CB-1:0]    saturation;
		logic [CB-1:0]    brightness;
	} hsv_t;

	logic clk;
	logic arst_n;

	rth_pix_if #(.CHANNEL_BITS(CB)) pix ();
	rth_hsv_if #(.CHANNEL_BITS(CB)) hsv ();

	rgb_to_hsv #(.CHANNEL_BITS(CB)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.hsv    (hsv)
	);

	hsv_t expected_hsv[$];
	int   mismatches;
	int   pixels_sent;
	int   results_checked;
	int   burst_left;
	bit   gaps_on;
	bit   rx_stall;
	int   hold_cycles;
	int   hold_total;

	function automatic hsv_t convert_pixel(input logic [CB-1:0] r, g, b);
		hsv_t        res;
		int unsigned mx;
		int unsigned mn;
		int unsigned delta;
		int unsigned scaled;
		max_sel_t    sel;
		mx = 32'(r);
		mn = 32'(r);
		if (g > mx) mx = 32'(g);
		if (b > mx) mx = 32'(b);
		if (g < mn) mn = 32'(g);
		if (b < mn) mn = 32'(b);
		delta = mx - mn;
		if (mx == r) sel = SEL_RED;
		else if (mx == g) sel = SEL_GREEN;
		else sel = SEL_BLUE;
		res.hue = '0;
		if (delta != 0) begin
			case (sel)
				SEL_RED: begin
					if (g >= b) scaled = g - b;
					else scaled = 6 * delta - (b - g);
				end
				SEL_GREEN: begin
					scaled = 2 * delta + b - r;
				end
				default: begin
					scaled = 4 * delta + r - g;
				end
			endcase
			res.hue = HUE_W'((scaled << SEXTANT_SHIFT) / delta);
		end
		res.saturation = (mx == 0) ? '0 : CB'((FULL * delta) / mx);
		res.brightness = CB'(mx);
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("rgb_to_hsv regression: fail");
		$finish;
	end

	// Receiver: a long hold-off if requested, a random stall pattern under rx_stall, else ready.
	initial begin : ready_driver
		logic [15:0] pattern;
		int          phase;
		pattern = '1;
		phase = 0;
		hsv.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase == 0) begin
				case ($urandom_range(0, 3))
					0: pattern = '1;
					1: pattern = 16'($urandom);
					2: pattern = 16'($urandom | $urandom);
					default: pattern = 16'($urandom & $urandom);
				endcase
			end
			phase = (phase + 1) % 16;
			if (hold_cycles > 0) begin
				hsv.ready <= 1'b0;
				hold_cycles--;
				hold_total++;
			end else if (rx_stall) begin
				hsv.ready <= pattern[phase];
			end else begin
				hsv.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && hsv.valid && hsv.ready) begin
			if (expected_hsv.size() == 0) begin
				$display("%0t: unexpected transfer hue=%0d sat=%0d val=%0d", $time,
					hsv.hue, hsv.saturation, hsv.brightness);
				mismatches++;
			end else begin
				hsv_t exp_item;
				exp_item = expected_hsv.pop_front();
				results_checked++;
				if (hsv.hue !== exp_item.hue) begin
					$display("%0t: hue expected %0d actual %0d", $time, exp_item.hue, hsv.hue);
					mismatches++;
				end
				if (hsv.saturation !== exp_item.saturation) begin
					$display("%0t: saturation expected %0d actual %0d", $time,
						exp_item.saturation, hsv.saturation);
					mismatches++;
				end
				if (hsv.brightness !== exp_item.brightness) begin
					$display("%0t: brightness expected %0d actual %0d", $time,
						exp_item.brightness, hsv.brightness);
					mismatches++;
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_pixel(input logic [CB-1:0] r, g, b);
		if (gaps_on && burst_left <= 0) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		pix.valid <= 1'b1;
		pix.red   <= r;
		pix.green <= g;
		pix.blue  <= b;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		expected_hsv.push_back(convert_pixel(r, g, b));
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_pixel();
		logic [CB-1:0] r, g, b, v;
		r = CB'($urandom);
		g = CB'($urandom);
		b = CB'($urandom);
		v = CB'($urandom);
		case ($urandom_range(0, 9))
			5: begin
				case ($urandom_range(0, 2))
					0: g = r;
					1: b = g;
					default: b = r;
				endcase
			end
			6: begin
				r = v;
				g = v;
				b = v;
			end
			7: begin
				r = $urandom_range(0, 1) ? FULL : '0;
				b = $urandom_range(0, 1) ? FULL : '0;
			end
			8: begin
				r = CB'($urandom_range(0, 3));
				g = CB'($urandom_range(0, 3));
				b = CB'($urandom_range(0, 3));
			end
			9: begin
				r = FULL - CB'($urandom_range(0, 15));
				g = CB'($urandom_range(0, 100));
				b = g + CB'($urandom_range(1, 100));
			end
			default: begin
			end
		endcase
		send_pixel(r, g, b);
	endtask

	task automatic test_special_colors();
		gaps_on = 1'b0;
		rx_stall = 1'b0;
		send_pixel(0, 0, 0);
		send_pixel(FULL, FULL, FULL);
		send_pixel(128, 128, 128);
		send_pixel(1, 1, 1);
		send_pixel(FULL, 0, 0);
		send_pixel(0, FULL, 0);
		send_pixel(0, 0, FULL);
		send_pixel(FULL, FULL, 0);
		send_pixel(0, FULL, FULL);
		send_pixel(FULL, 0, FULL);
		send_pixel(FULL, 0, 1);
		send_pixel(1, 0, 0);
		send_pixel(0, 0, 1);
		send_pixel(200, FULL, 0);
		send_pixel(0, 100, FULL);
		send_pixel(FULL, FULL - 1'b1, FULL - 1'b1);
		send_pixel(8'h55, 8'hAA, 8'h0F);
		send_pixel(8'hAA, 8'h55, 8'hF0);
	endtask

	task automatic test_random_pixels();
		gaps_on = 1'b1;
		rx_stall = 1'b1;
		repeat (160) send_random_pixel();
		rx_stall = 1'b0;
		repeat (120) send_random_pixel();
		gaps_on = 1'b0;
		rx_stall = 1'b1;
		repeat (120) send_random_pixel();
	endtask

	task automatic test_output_hold_off();
		gaps_on = 1'b0;
		rx_stall = 1'b0;
		hold_cycles = 60;
		repeat (70) send_random_pixel();
		rx_stall = 1'b1;
		gaps_on = 1'b1;
		hold_cycles = 40;
		repeat (60) send_random_pixel();
	endtask

	initial begin
		mismatches = 0;
		pixels_sent = 0;
		results_checked = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		rx_stall = 1'b0;
		hold_cycles = 0;
		hold_total = 0;
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.red = '0;
		pix.green = '0;
		pix.blue = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_special_colors();
		test_random_pixels();
		test_output_hold_off();
		pix.valid <= 1'b0;

		while (expected_hsv.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Converted %0d pixels, checked %0d results, with %0d cycles of output hold-off.",
			pixels_sent, results_checked, hold_total);
		$display("Covered grey, black, primary, tie and wrapped-red-hue pixels %s",
			"under random flow control.");
		if (mismatches == 0) begin
			$display("rgb_to_hsv regression: pass");
		end else begin
			$display("rgb_to_hsv regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
design/rth_pkg.sv
design/rth_pix_if.sv
design/rth_hsv_if.sv
design/rth_front.sv
design/rth_div.sv
design/rgb_to_hsv.sv
test/tb_rgb_to_hsv.sv
